// ----- sv/bmp_pixel_stream_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// bmp pixel stream decoder assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BMP_PIXEL_STREAM_DECODER_DEFINES_SVH
`define BMP_PIXEL_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BMPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bmpd assertion failed");
// next-cycle implication
`define BMPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmpd assertion failed");
`else
`define BMPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/bmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the bitmap pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpd_pkg;

	// header field start positions
	localparam int unsigned OFF_POS    = 10;
	localparam int unsigned WID_POS    = 18;
	localparam int unsigned HGT_POS    = 22;
	localparam int unsigned BPP_POS    = 28;
	localparam int unsigned HDR_LAST   = 31;
	localparam int unsigned MIN_OFFSET = 32;
	localparam int unsigned BYTE_BITS  = 8;
	localparam logic [63:0] MAX_PIXELS = 64'd268435455;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BODY,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_MISMATCH  = 4'd2,
		ST_CHANNELS  = 4'd3,
		ST_WIDTH     = 4'd4,
		ST_HEIGHT    = 4'd5,
		ST_OFFSET    = 4'd6,
		ST_TOO_LARGE = 4'd7,
		ST_TRUNCATED = 4'd8,
		ST_LIMITS    = 4'd9
	} status_t;

	typedef struct packed {
		logic        is_error;
		status_t     status;
		logic [7:0]  first_value;
		logic [7:0]  second_value;
		logic [7:0]  third_value;
		logic [7:0]  fourth_value;
		logic [15:0] row_index;
		logic [15:0] column_index;
		logic        last;
	} res_t;

	function automatic res_t make_err(status_t st);
		res_t r;
		r          = '0;
		r.is_error = 1'b1;
		r.status   = st;
		r.last     = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/bmpd_byte_if.sv -----
// ----------------------------------------------------------------------------
// bmpd_byte_if
// File byte channel: one bitmap file byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       end_of_file;

	modport source (output valid, output byte_value, output end_of_file, input ready);
	modport sink (input valid, input byte_value, input end_of_file, output ready);
endinterface

`default_nettype wire

// ----- sv/bmpd_pixel_if.sv -----
// ----------------------------------------------------------------------------
// bmpd_pixel_if
// Result channel: one pixel or one error per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpd_pixel_if;
	logic        valid;
	logic        ready;
	logic        is_error;
	logic [3:0]  status;
	logic [7:0]  first_value;
	logic [7:0]  second_value;
	logic [7:0]  third_value;
	logic [7:0]  fourth_value;
	logic [15:0] row_index;
	logic [15:0] column_index;
	logic        last;

	modport source (
		output valid, output is_error, output status, output first_value,
		output second_value, output third_value, output fourth_value,
		output row_index, output column_index, output last, input ready
	);
	modport sink (
		input valid, input is_error, input status, input first_value,
		input second_value, input third_value, input fourth_value,
		input row_index, input column_index, input last, output ready
	);
endinterface

`default_nettype wire

// ----- sv/bmp_pixel_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// Streams an uncompressed bitmap file in and pixels or an error out.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : one file byte per beat, end_of_file set on the final byte.
//   pixels : one pixel per beat with row/column, last on the final pixel;
//            a bad header or an early end gives one error beat with last set,
//            after which the consumer drops the pixels already taken.
//   cfg_we / cfg_wdata : channel setting (0 follows the file, else 1, 3 or 4);
//            write only while no file is in progress.
// Throughput: one byte per cycle while bytes.ready is high; every accepted byte updates the counters.
// Results are registered in the output buffer before they appear on pixels.
// Stall: results sit in a two-entry output buffer; bytes.ready falls only
//   when both entries hold results, so a stalled consumer backs up the input
//   after two pending results.
// Reset: clears the file state but the |height| and product registers, the
//   channel setting and the output buffer; the next byte is byte 0 of a
//   file. Any end_of_file beat also rearms for a new file.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmp_pixel_stream_decoder_defines.svh"

module bmp_pixel_stream_decoder
	import bmpd_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	bmpd_byte_if.sink       bytes,
	bmpd_pixel_if.source    pixels
);

	logic acc;
	logic buf_ready;
	logic res_valid;
	res_t res;

	assign bytes.ready = buf_ready;
	assign acc         = bytes.valid && buf_ready;

	bmpd_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.acc         (acc),
		.byte_value  (bytes.byte_value),
		.end_of_file (bytes.end_of_file),
		.res_valid   (res_valid),
		.res         (res)
	);

	bmpd_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.res    (res),
		.ready  (buf_ready),
		.pixels (pixels)
	);

	`BMPD_ASSERT_IMP(a_err_last, clk, arst_n, pixels.valid && pixels.is_error, pixels.last)
	`BMPD_ASSERT_IMP(a_err_zero, clk, arst_n, pixels.valid && pixels.is_error,
		pixels.first_value == 8'd0 && pixels.row_index == 16'd0
		&& pixels.column_index == 16'd0)
	`BMPD_ASSERT_IMP(a_pix_ok, clk, arst_n, pixels.valid && !pixels.is_error, pixels.status == ST_OK)
	`BMPD_ASSERT_IMP(a_full_valid, clk, arst_n, !buf_ready, pixels.valid)
	`BMPD_ASSERT_NXT(a_res_shown, clk, arst_n, res_valid, pixels.valid)

endmodule

`default_nettype wire

// ----- sv/bmpd_core.sv -----
// ----------------------------------------------------------------------------
// bmpd_core
// Header capture and checks, offset skip, row padding and pixel assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_core
	import bmpd_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire logic       acc,
	input  wire logic [7:0] byte_value,
	input  wire logic       end_of_file,
	output logic            res_valid,
	output res_t            res
);

	localparam logic [31:0] LIM = 32'd1 << COORD_BITS;

	logic [2:0]            chan_set_q;
	logic [31:0]           cnt_q, cnt_d;
	logic [31:0]           off_q, off_d;
	logic [31:0]           wid_q, wid_d;
	logic [31:0]           hgt_q, hgt_d;
	logic [31:0]           bpp_q, bpp_d;
	logic [31:0]           ah_q;
	logic [63:0]           prod_q;
	logic [2:0]            ach_q, ach_d;
	logic [COORD_BITS-1:0] row_q, row_d;
	logic [COORD_BITS-1:0] col_q, col_d;
	logic [1:0]            pix_q, pix_d;
	logic [23:0]           held_q, held_d;
	logic [1:0]            pad_q, pad_d;
	phase_t                phase_q, phase_d;

	logic [1:0]            lane;
	logic [4:0]            lane_sh;
	logic [2:0]            file_ch, ch_sel;
	status_t               chk;
	logic [COORD_BITS:0]   row_out, col_inc, row_inc;
	logic [31:0]           row_w, col_w;
	logic [1:0]            pad_mod;

	// header field capture, one byte lane per beat
	always_comb begin
		off_d   = off_q;
		wid_d   = wid_q;
		hgt_d   = hgt_q;
		bpp_d   = bpp_q;
		lane    = cnt_q[1:0] - 2'd2;
		lane_sh = {lane, 3'b000};
		if (phase_q == PH_HEADER) begin
			priority if (cnt_q >= OFF_POS && cnt_q <= OFF_POS + 3) begin
				off_d[lane_sh +: 8] = byte_value;
			end else if (cnt_q >= WID_POS && cnt_q <= WID_POS + 3) begin
				wid_d[lane_sh +: 8] = byte_value;
			end else if (cnt_q >= HGT_POS && cnt_q <= HGT_POS + 3) begin
				hgt_d[lane_sh +: 8] = byte_value;
			end else if (cnt_q >= BPP_POS && cnt_q <= BPP_POS + 3) begin
				bpp_d[{cnt_q[1:0], 3'b000} +: 8] = byte_value;
			end else begin
				off_d = off_q;
			end
		end
	end

	// header checks, in priority order
	always_comb begin
		file_ch = (!bpp_d[31] && bpp_d[30:6] == '0) ? bpp_d[5:3] : 3'd0;
		ch_sel  = (chan_set_q != 3'd0) ? chan_set_q : file_ch;
		priority if (chan_set_q != 3'd0 && chan_set_q != file_ch) begin
			chk = ST_MISMATCH;
		end else if (ch_sel != 3'd1 && ch_sel != 3'd3 && ch_sel != 3'd4) begin
			chk = ST_CHANNELS;
		end else if (wid_q == '0 || wid_q[31]) begin
			chk = ST_WIDTH;
		end else if (hgt_q == '0) begin
			chk = ST_HEIGHT;
		end else if (off_q[31] || off_q < MIN_OFFSET) begin
			chk = ST_OFFSET;
		end else if (prod_q >= MAX_PIXELS) begin
			chk = ST_TOO_LARGE;
		end else if (wid_q > LIM || ah_q > LIM) begin
			chk = ST_LIMITS;
		end else begin
			chk = ST_OK;
		end
	end

	// pixel coordinates; body values are bounded by the limits check
	always_comb begin
		row_out = hgt_q[31] ? {1'b0, row_q}
			: ah_q[COORD_BITS:0] - (COORD_BITS+1)'(1) - {1'b0, row_q};
		row_w   = 32'(row_out);
		col_w   = 32'(col_q);
		col_inc = {1'b0, col_q} + (COORD_BITS+1)'(1);
		row_inc = {1'b0, row_q} + (COORD_BITS+1)'(1);
		pad_mod = 2'(ach_q[1:0] * wid_q[1:0]);
	end

	always_comb begin
		cnt_d     = cnt_q;
		ach_d     = ach_q;
		row_d     = row_q;
		col_d     = col_q;
		pix_d     = pix_q;
		held_d    = held_q;
		pad_d     = pad_q;
		phase_d   = phase_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_HEADER: begin
				cnt_d = cnt_q + 32'd1;
				if (cnt_q >= HDR_LAST) begin
					if (chk != ST_OK) begin
						res_valid = 1'b1;
						res       = make_err(chk);
						phase_d   = PH_DONE;
					end else begin
						ach_d   = ch_sel;
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				priority if (cnt_q < off_q) begin
					cnt_d = cnt_q + 32'd1;
				end else if (pad_q != 2'd0) begin
					pad_d = pad_q - 2'd1;
				end else if ({1'b0, pix_q} + 3'd1 < ach_q) begin
					held_d = held_q | (24'(byte_value) << {pix_q, 3'b000});
					pix_d  = pix_q + 2'd1;
				end else begin
					res_valid = 1'b1;
					unique case (ach_q)
						3'd1: begin
							res.first_value = byte_value;
						end
						3'd3: begin
							res.first_value  = byte_value;
							res.second_value = held_q[15:8];
							res.third_value  = held_q[7:0];
						end
						default: begin
							res.first_value  = held_q[23:16];
							res.second_value = held_q[15:8];
							res.third_value  = held_q[7:0];
							res.fourth_value = byte_value;
						end
					endcase
					res.row_index    = row_w[15:0];
					res.column_index = col_w[15:0];
					pix_d            = 2'd0;
					held_d           = '0;
					if (col_inc >= wid_q[COORD_BITS:0]) begin
						col_d = '0;
						if (row_inc >= ah_q[COORD_BITS:0]) begin
							res.last = 1'b1;
							phase_d  = PH_DONE;
						end else begin
							row_d = row_q + COORD_BITS'(1);
							pad_d = 2'd0 - pad_mod;
						end
					end else begin
						col_d = col_q + COORD_BITS'(1);
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// end of file closes the current file and rearms for the next
		if (end_of_file) begin
			if (phase_d == PH_HEADER) begin
				res_valid = 1'b1;
				res       = make_err(ST_SHORT);
			end else if (phase_d == PH_BODY) begin
				res_valid = 1'b1;
				res       = make_err(ST_TRUNCATED);
			end
			cnt_d   = '0;
			ach_d   = '0;
			row_d   = '0;
			col_d   = '0;
			pix_d   = '0;
			held_d  = '0;
			pad_d   = '0;
			phase_d = PH_HEADER;
		end
		res_valid = res_valid & acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_set_q <= '0;
			cnt_q      <= '0;
			off_q      <= '0;
			wid_q      <= '0;
			hgt_q      <= '0;
			bpp_q      <= '0;
			ach_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pix_q      <= '0;
			held_q     <= '0;
			pad_q      <= '0;
			phase_q    <= PH_HEADER;
		end else begin
			if (cfg_we) begin
				chan_set_q <= cfg_wdata;
			end
			if (acc) begin
				cnt_q   <= cnt_d;
				ach_q   <= ach_d;
				row_q   <= row_d;
				col_q   <= col_d;
				pix_q   <= pix_d;
				held_q  <= held_d;
				pad_q   <= pad_d;
				phase_q <= phase_d;
				if (end_of_file) begin
					off_q <= '0;
					wid_q <= '0;
					hgt_q <= '0;
					bpp_q <= '0;
				end else begin
					off_q <= off_d;
					wid_q <= wid_d;
					hgt_q <= hgt_d;
					bpp_q <= bpp_d;
				end
			end
		end
	end

	// |height| once the height bytes are in, then the pixel count product
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_HEADER) begin
			if (cnt_q == HGT_POS + 4) begin
				ah_q <= hgt_q[31] ? (~hgt_q) + 32'd1 : hgt_q;
			end
			if (cnt_q > HGT_POS + 4 && cnt_q < HDR_LAST) begin
				prod_q <= 64'(wid_q) * 64'(ah_q);
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bmpd_out_buf.sv -----
// ----------------------------------------------------------------------------
// bmpd_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_out_buf
	import bmpd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire res_t     res,
	output logic          ready,
	bmpd_pixel_if.source  pixels
);

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop   = main_v_q && pixels.ready;
	assign ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= push;
				end
			end else if (!main_v_q) begin
				main_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			main_q <= skid_q;
		end else if (pop || !main_v_q) begin
			main_q <= res;
		end
		if (!pop && main_v_q && push) begin
			skid_q <= res;
		end
	end

	assign pixels.valid        = main_v_q;
	assign pixels.is_error     = main_q.is_error;
	assign pixels.status       = main_q.status;
	assign pixels.first_value  = main_q.first_value;
	assign pixels.second_value = main_q.second_value;
	assign pixels.third_value  = main_q.third_value;
	assign pixels.fourth_value = main_q.fourth_value;
	assign pixels.row_index    = main_q.row_index;
	assign pixels.column_index = main_q.column_index;
	assign pixels.last         = main_q.last;

endmodule

`default_nettype wire
